// ===== rtl/core/aso_pkg.sv =====
// Shared widths, constants and controller/datapath handshake types for the square oscillator.
package aso_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FREQ_W        = 24;
   localparam int SR_W          = 18;
   localparam int PHASE_W       = 40;
   localparam int OUT_W         = 16;
   localparam int FREQ_FRAC_W   = 8;

   localparam logic [SR_W-1:0]         SR_RESET = SR_W'(48000);
   localparam logic signed [OUT_W-1:0] OUT_MAX  = 16'sh7FFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN  = 16'sh8000;
   localparam logic signed [OUT_W-1:0] OUT_ZERO = 16'sh0000;

   typedef struct packed {
      logic latch;        // capture the incoming word
      logic clear;        // zero frequency: silence and reset phase
      logic div_start;    // begin period division
      logic load_period;  // take saturated quotient
      logic step;         // advance phase by one sample
      logic wrap;         // reduce phase by period once
      logic eval;         // edge flags and fraction
      logic fin;          // form the output level
      logic out_load;     // move result to output register
   } cmd_type;

   typedef struct packed {
      logic freq_zero;
      logic freq_changed;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/core/aso_if.sv =====
// Valid/ready channel interfaces for frequency words in and sample words out.
interface aso_req_if;
   import aso_pkg::*;
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] freq;
   modport source (output valid, output freq, input ready);
   modport sink   (input valid, input freq, output ready);
endinterface

interface aso_rsp_if;
   import aso_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/core/aso_ctrl.sv =====
// Sequencing state machine for the square oscillator.
module aso_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  aso_pkg::status_type status,
   output aso_pkg::cmd_type    cmd
);
   import aso_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_DIV, S_STEP, S_WRAP, S_EVAL, S_FIN, S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd             = '0;
      cmd.latch       = (state_ff == S_IDLE) && req_valid;
      cmd.clear       = (state_ff == S_CHECK) && status.freq_zero;
      cmd.div_start   = (state_ff == S_CHECK) && !status.freq_zero && status.freq_changed;
      cmd.load_period = (state_ff == S_DIV) && status.div_done;
      cmd.step        = (state_ff == S_STEP);
      cmd.wrap        = (state_ff == S_WRAP);
      cmd.eval        = (state_ff == S_EVAL);
      cmd.fin         = (state_ff == S_FIN);
      cmd.out_load    = (state_ff == S_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a word taken in the same cycle as a new load stays valid
         if (rsp_valid_ff && rsp_ready && !cmd.out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (status.freq_zero)         state_ff <= S_DONE;
               else if (status.freq_changed) state_ff <= S_DIV;
               else                          state_ff <= S_STEP;
            end
            S_DIV: begin
               if (status.div_done) state_ff <= S_STEP;
            end
            S_STEP: state_ff <= S_WRAP;
            S_WRAP: state_ff <= S_EVAL;
            S_EVAL: state_ff <= S_FIN;
            S_FIN:  state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/aso_dp.sv =====
// Datapath: period divider, phase accumulator, edge averaging and output register.
module aso_dp #(
   parameter int FRAC_BITS = aso_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  aso_pkg::cmd_type                cmd,
   output aso_pkg::status_type             status,
   input  logic [aso_pkg::FREQ_W-1:0]      req_freq,
   input  logic                            csr_we,
   input  logic [aso_pkg::SR_W-1:0]        csr_wdata,
   output logic signed [aso_pkg::OUT_W-1:0] rsp_sample_out
);
   import aso_pkg::*;

   localparam int DVD_W = SR_W + FREQ_FRAC_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [PHASE_W:0] ONE = {{PHASE_W{1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [17:0] MID = 18'sd32768;
   localparam logic signed [17:0] TOP = 18'sd32767;

   logic [SR_W-1:0]    sample_rate_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic [FREQ_W-1:0]  last_freq_ff;
   logic [PHASE_W-1:0] period_ff;
   logic [PHASE_W-1:0] phase_ff;

   // divider
   logic [DVD_W-1:0]   dvd_ff;
   logic [FREQ_W-1:0]  rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [FREQ_W:0]    trial;
   logic [FREQ_W:0]    trial_sub;
   logic               trial_ge;
   logic [PHASE_W-1:0] quot_sat;

   // edge evaluation
   logic [PHASE_W-1:0] half;
   logic               hi;
   logic [PHASE_W-1:0] minuend;
   logic [PHASE_W:0]   sum_one;
   logic [PHASE_W:0]   diff;
   logic               hi_ff;
   logic               edge_ff;
   logic [FRAC_BITS:0] frac_ff;
   logic [FRAC_BITS:0] frac_in;

   // level
   logic [FRAC_BITS+16:0] frac_wide;
   logic [16:0]           twice;
   logic signed [17:0]    lvl;
   logic signed [OUT_W-1:0] res_ff;
   logic signed [OUT_W-1:0] lvl_sat;
   logic signed [OUT_W-1:0] out_ff;

   assign status.freq_zero    = (freq_ff == '0);
   assign status.freq_changed = (freq_ff != last_freq_ff);
   assign status.div_done     = (cnt_ff == '0);
   assign rsp_sample_out      = out_ff;

   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge  = (trial >= {1'b0, freq_ff});
   assign trial_sub = trial - {1'b0, freq_ff};

   generate
      if (DVD_W > PHASE_W) begin : g_sat
         assign quot_sat = (|dvd_ff[DVD_W-1:PHASE_W]) ? '1 : dvd_ff[PHASE_W-1:0];
      end else begin : g_nosat
         assign quot_sat = PHASE_W'(dvd_ff);
      end
   endgenerate

   assign half    = period_ff >> 1;
   assign hi      = (phase_ff >= half);
   assign minuend = hi ? period_ff : half;
   assign sum_one = {1'b0, phase_ff} + ONE;
   assign diff    = {1'b0, minuend} - {1'b0, phase_ff};

   always_comb begin
      if (diff[PHASE_W])          frac_in = '0;
      else if (diff > ONE)        frac_in = ONE[FRAC_BITS:0];
      else                        frac_in = diff[FRAC_BITS:0];
   end

   assign frac_wide = {frac_ff, 16'b0} >> FRAC_BITS;
   assign twice     = frac_wide[16:0];

   always_comb begin
      if (hi_ff) lvl = $signed({1'b0, twice}) - MID;
      else       lvl = MID - $signed({1'b0, twice});
      if (lvl > TOP) lvl_sat = OUT_MAX;
      else           lvl_sat = lvl[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SR_RESET;
         last_freq_ff   <= '0;
         period_ff      <= '0;
         phase_ff       <= '0;
         cnt_ff         <= '0;
      end else begin
         if (csr_we) sample_rate_ff <= csr_wdata;
         if (cmd.clear) begin
            phase_ff     <= '0;
            last_freq_ff <= '0;
         end
         if (cmd.div_start) begin
            cnt_ff <= CNT_W'(DVD_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.load_period) begin
            period_ff    <= quot_sat;
            last_freq_ff <= freq_ff;
         end
         if (cmd.step) phase_ff <= phase_ff + ONE[PHASE_W-1:0];
         if (cmd.wrap && (phase_ff >= period_ff)) phase_ff <= phase_ff - period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) freq_ff <= req_freq;
      if (cmd.div_start) begin
         dvd_ff <= DVD_W'(sample_rate_ff) << (FREQ_FRAC_W + FRAC_BITS);
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], trial_ge};
         rem_ff <= trial_ge ? trial_sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
      end
      if (cmd.eval) begin
         hi_ff   <= hi;
         edge_ff <= (sum_one > {1'b0, minuend});
         frac_ff <= frac_in;
      end
      if (cmd.clear) res_ff <= OUT_ZERO;
      if (cmd.fin) begin
         if (edge_ff)    res_ff <= lvl_sat;
         else if (hi_ff) res_ff <= OUT_MAX;
         else            res_ff <= OUT_MIN;
      end
      if (cmd.out_load) out_ff <= res_ff;
   end

endmodule

// ===== rtl/core/antialiased_square_oscillator.sv =====
// Each accepted word runs the states check, step, wrap, eval, fin and done in order;
// a zero frequency goes from check straight to done, and a frequency change inserts the
// period divide after check, a restoring divider giving one quotient bit a cycle.
// A new word is taken only once the current one leaves done; rsp stalls hold it in done.
// A new word is accepted while the previous result waits in the output register.
// Reset (synchronous): phase, period and last frequency clear, sample rate returns to 48000.
module antialiased_square_oscillator #(
   parameter int FRAC_BITS = aso_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   aso_req_if.sink                   req_if,
   aso_rsp_if.source                 rsp_if,
   input  logic                      csr_we,
   input  logic [aso_pkg::SR_W-1:0]  csr_wdata
);
   import aso_pkg::*;

   cmd_type    cmd;
   status_type status;

   aso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   aso_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_freq       (req_if.freq),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_sample_out (rsp_if.sample_out)
   );

endmodule
